### rtl/multi_pattern_byte_matcher_top_assert.svh
// Assertion macros for the multi-pattern byte matcher
`ifndef MULTI_PATTERN_BYTE_MATCHER_TOP_ASSERT_SVH
`define MULTI_PATTERN_BYTE_MATCHER_TOP_ASSERT_SVH

// same-cycle implication
`define MPBM_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPBM_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mpbm_pkg.sv
// Types and codes shared by the multi-pattern byte matcher
package mpbm_pkg;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_BUILD = 2'd1;
    localparam logic [1:0] FUNC_TEXT  = 2'd2;

    localparam logic [2:0] KIND_LITERAL = 3'd0;
    localparam logic [2:0] KIND_MATCH   = 3'd1;
    localparam logic [2:0] KIND_LOAD_OK = 3'd2;
    localparam logic [2:0] KIND_LOAD_RJ = 3'd3;
    localparam logic [2:0] KIND_BUILT   = 3'd4;

    typedef enum logic [13:0] {
        ST_CLEAR   = 14'b00000000000001,
        ST_IDLE    = 14'b00000000000010,
        ST_LD_CHK  = 14'b00000000000100,
        ST_TX_GO   = 14'b00000000001000,
        ST_TX_FAIL = 14'b00000000010000,
        ST_TX_CHK  = 14'b00000000100000,
        ST_BD_POP  = 14'b00000001000000,
        ST_BD_Q    = 14'b00000010000000,
        ST_BD_EC   = 14'b00000100000000,
        ST_BD_FT   = 14'b00001000000000,
        ST_BD_FN   = 14'b00010000000000,
        ST_BD_WR   = 14'b00100000000000,
        ST_EMIT    = 14'b01000000000000,
        ST_SPARE   = 14'b10000000000000
    } state_t;

endpackage

### rtl/multi_pattern_byte_matcher_top.sv
// A load byte reads the goto table before it is answered; one rejected at accept skips it.
// A text byte follows goto and failure links (a zero byte skips them); a build visits
// each queued node's symbols and walks failure links per child; m_ready stalls delay each.
// Throughput: one item at a time; s_ready returns as m_valid presents the result word.
// Reset: synchronous, active low; then a clearing pass over all MAX_NODES*ALPHABET entries
// zeroes the goto table while s_ready stays low.
`include "multi_pattern_byte_matcher_top_assert.svh"
module multi_pattern_byte_matcher_top
    import mpbm_pkg::*;
#(
    parameter int MAX_NODES       = 1024,
    parameter int MAX_PATTERN_LEN = 255,
    parameter int ALPHABET        = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_out_byte,
    output logic [7:0]  m_match_length,
    output logic [10:0] m_match_label,
    output logic        m_first_time
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int SW  = $clog2(ALPHABET);
    localparam int LW  = $clog2(MAX_PATTERN_LEN + 1);
    localparam int BW  = NW + 1;
    localparam int GAW = NW + SW;
    localparam int GD  = MAX_NODES * (1 << SW);

    logic [NW-1:0] goto_mem  [GD];
    logic [NW-1:0] fail_mem  [MAX_NODES];
    logic [LW-1:0] end_mem   [MAX_NODES];
    logic [BW-1:0] label_mem [MAX_NODES];
    logic [NW-1:0] queue_mem [MAX_NODES];

    logic [NW-1:0] goto_q, fail_q, queue_q;
    logic [LW-1:0] end_q;
    logic [BW-1:0] label_q;

    logic           goto_re, goto_we, fail_re, fail_we, nl_re, end_we, lab_we, q_re, q_we;
    logic [GAW-1:0] goto_raddr, goto_waddr;
    logic [NW-1:0]  goto_wdata, fail_raddr, fail_waddr, fail_wdata, nl_raddr;
    logic [NW-1:0]  end_waddr, lab_waddr, q_raddr, q_waddr, q_wdata;
    logic [LW-1:0]  end_wdata;
    logic [BW-1:0]  lab_wdata;

    state_t         state_reg, state_next;
    logic [GAW-1:0] clr_reg, clr_next;
    logic [7:0]     byte_reg, byte_next;
    logic           last_reg, last_next;
    logic [BW-1:0]  node_count_reg, node_count_next;
    logic [BW-1:0]  label_count_reg, label_count_next;
    logic [NW-1:0]  load_cursor_reg, load_cursor_next;
    logic [LW-1:0]  load_depth_reg, load_depth_next;
    logic           load_discard_reg, load_discard_next;
    logic [NW-1:0]  match_cursor_reg, match_cursor_next;
    logic [NW-1:0]  p_reg, p_next;
    logic [NW-1:0]  q_reg, q_next;
    logic [NW-1:0]  c_reg, c_next;
    logic [NW-1:0]  t_reg, t_next;
    logic [NW-1:0]  f_reg, f_next;
    logic [SW-1:0]  s_reg, s_next;
    logic [BW-1:0]  head_reg, head_next;
    logic [BW-1:0]  tail_reg, tail_next;

    logic [2:0]     res_kind_reg, res_kind_next;
    logic [7:0]     res_byte_reg, res_byte_next;
    logic [7:0]     res_len_reg, res_len_next;
    logic [10:0]    res_label_reg, res_label_next;
    logic           res_first_reg, res_first_next;

    logic           m_valid_reg, m_valid_next;
    logic [2:0]     m_kind_reg, m_kind_next;
    logic [7:0]     m_out_byte_reg, m_out_byte_next;
    logic [7:0]     m_match_length_reg, m_match_length_next;
    logic [10:0]    m_match_label_reg, m_match_label_next;
    logic           m_first_time_reg, m_first_time_next;

    logic           s_sym_ok;
    logic [BW-1:0]  new_label;
    logic [31:0]    len_wide, lab_wide;

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_out_byte     = m_out_byte_reg;
    assign m_match_length = m_match_length_reg;
    assign m_match_label  = m_match_label_reg;
    assign m_first_time   = m_first_time_reg;

    assign s_sym_ok  = (s_data_byte != 8'd0) && ({1'b0, s_data_byte} < 9'(ALPHABET));
    assign new_label = (label_q == '0) ? label_count_reg + BW'(1) : label_q;
    assign len_wide  = 32'(end_q);
    assign lab_wide  = 32'(new_label);

    always_comb begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        byte_next         = byte_reg;
        last_next         = last_reg;
        node_count_next   = node_count_reg;
        label_count_next  = label_count_reg;
        load_cursor_next  = load_cursor_reg;
        load_depth_next   = load_depth_reg;
        load_discard_next = load_discard_reg;
        match_cursor_next = match_cursor_reg;
        p_next            = p_reg;
        q_next            = q_reg;
        c_next            = c_reg;
        t_next            = t_reg;
        f_next            = f_reg;
        s_next            = s_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        res_kind_next     = res_kind_reg;
        res_byte_next     = res_byte_reg;
        res_len_next      = res_len_reg;
        res_label_next    = res_label_reg;
        res_first_next    = res_first_reg;

        m_valid_next        = m_valid_reg && !m_ready;
        m_kind_next         = m_kind_reg;
        m_out_byte_next     = m_out_byte_reg;
        m_match_length_next = m_match_length_reg;
        m_match_label_next  = m_match_label_reg;
        m_first_time_next   = m_first_time_reg;

        goto_re = 1'b0;  goto_raddr = '0;
        goto_we = 1'b0;  goto_waddr = '0;  goto_wdata = '0;
        fail_re = 1'b0;  fail_raddr = '0;
        fail_we = 1'b0;  fail_waddr = '0;  fail_wdata = '0;
        nl_re   = 1'b0;  nl_raddr   = '0;
        end_we  = 1'b0;  end_waddr  = '0;  end_wdata  = '0;
        lab_we  = 1'b0;  lab_waddr  = '0;  lab_wdata  = '0;
        q_re    = 1'b0;  q_raddr    = '0;
        q_we    = 1'b0;  q_waddr    = '0;  q_wdata    = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                goto_we    = 1'b1;
                goto_waddr = clr_reg;
                clr_next   = clr_reg + GAW'(1);
                if (clr_reg == GAW'(GD - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    byte_next      = s_data_byte;
                    last_next      = s_last;
                    res_byte_next  = 8'd0;
                    res_len_next   = 8'd0;
                    res_label_next = 11'd0;
                    res_first_next = 1'b0;
                    priority if (s_func == FUNC_LOAD) begin
                        if (load_discard_reg || !s_sym_ok ||
                            load_depth_reg >= LW'(MAX_PATTERN_LEN)) begin
                            if (s_last) begin
                                load_cursor_next  = '0;
                                load_depth_next   = '0;
                                load_discard_next = 1'b0;
                            end else begin
                                load_discard_next = 1'b1;
                            end
                            res_kind_next = KIND_LOAD_RJ;
                            state_next    = ST_EMIT;
                        end else begin
                            goto_re    = 1'b1;
                            goto_raddr = {load_cursor_reg, s_data_byte[SW-1:0]};
                            state_next = ST_LD_CHK;
                        end
                    end else if (s_func == FUNC_BUILD) begin
                        q_we       = 1'b1;
                        q_waddr    = '0;
                        q_wdata    = '0;
                        head_next  = '0;
                        tail_next  = BW'(1);
                        state_next = ST_BD_POP;
                    end else if (s_func == FUNC_TEXT) begin
                        if (s_sym_ok) begin
                            goto_re    = 1'b1;
                            goto_raddr = {match_cursor_reg, s_data_byte[SW-1:0]};
                            p_next     = match_cursor_reg;
                            state_next = ST_TX_GO;
                        end else begin
                            p_next     = '0;
                            state_next = ST_TX_CHK;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LD_CHK: begin
                res_kind_next = KIND_LOAD_OK;
                state_next    = ST_EMIT;
                if (goto_q == '0 && node_count_reg >= BW'(MAX_NODES)) begin
                    if (last_reg) begin
                        load_cursor_next  = '0;
                        load_depth_next   = '0;
                        load_discard_next = 1'b0;
                    end else begin
                        load_discard_next = 1'b1;
                    end
                    res_kind_next = KIND_LOAD_RJ;
                end else begin
                    if (goto_q == '0) begin
                        goto_we         = 1'b1;
                        goto_waddr      = {load_cursor_reg, byte_reg[SW-1:0]};
                        goto_wdata      = node_count_reg[NW-1:0];
                        fail_we         = 1'b1;
                        fail_waddr      = node_count_reg[NW-1:0];
                        lab_we          = 1'b1;
                        lab_waddr       = node_count_reg[NW-1:0];
                        end_we          = 1'b1;
                        end_waddr       = node_count_reg[NW-1:0];
                        end_wdata       = last_reg ? load_depth_reg + LW'(1) : '0;
                        node_count_next = node_count_reg + BW'(1);
                        load_cursor_next = node_count_reg[NW-1:0];
                    end else begin
                        end_we           = last_reg;
                        end_waddr        = goto_q;
                        end_wdata        = load_depth_reg + LW'(1);
                        load_cursor_next = goto_q;
                    end
                    load_depth_next = load_depth_reg + LW'(1);
                    if (last_reg) begin
                        load_cursor_next = '0;
                        load_depth_next  = '0;
                    end
                end
            end
            ST_TX_GO: begin
                if (goto_q != '0) begin
                    p_next     = goto_q;
                    nl_re      = 1'b1;
                    nl_raddr   = goto_q;
                    state_next = ST_TX_CHK;
                end else if (p_reg == '0) begin
                    state_next = ST_TX_CHK;
                end else begin
                    fail_re    = 1'b1;
                    fail_raddr = p_reg;
                    state_next = ST_TX_FAIL;
                end
            end
            ST_TX_FAIL: begin
                p_next     = fail_q;
                goto_re    = 1'b1;
                goto_raddr = {fail_q, byte_reg[SW-1:0]};
                state_next = ST_TX_GO;
            end
            ST_TX_CHK: begin
                state_next = ST_EMIT;
                if (p_reg != '0 && end_q != '0) begin
                    res_kind_next     = KIND_MATCH;
                    res_len_next      = len_wide[7:0];
                    res_label_next    = lab_wide[10:0];
                    match_cursor_next = '0;
                    if (label_q == '0) begin
                        lab_we           = 1'b1;
                        lab_waddr        = p_reg;
                        lab_wdata        = new_label;
                        label_count_next = new_label;
                        res_first_next   = 1'b1;
                    end
                end else begin
                    res_kind_next     = KIND_LITERAL;
                    res_byte_next     = byte_reg;
                    match_cursor_next = p_reg;
                end
            end
            ST_BD_POP: begin
                if (head_reg != tail_reg && head_reg < BW'(MAX_NODES)) begin
                    q_re       = 1'b1;
                    q_raddr    = head_reg[NW-1:0];
                    head_next  = head_reg + BW'(1);
                    state_next = ST_BD_Q;
                end else begin
                    res_kind_next = KIND_BUILT;
                    state_next    = ST_EMIT;
                end
            end
            ST_BD_Q: begin
                q_next     = queue_q;
                s_next     = SW'(1);
                goto_re    = 1'b1;
                goto_raddr = {queue_q, SW'(1)};
                state_next = ST_BD_EC;
            end
            ST_BD_EC: begin
                if (goto_q == '0) begin
                    if (s_reg == SW'(ALPHABET - 1)) begin
                        state_next = ST_BD_POP;
                    end else begin
                        s_next     = s_reg + SW'(1);
                        goto_re    = 1'b1;
                        goto_raddr = {q_reg, s_reg + SW'(1)};
                        state_next = ST_BD_EC;
                    end
                end else begin
                    c_next = goto_q;
                    if (q_reg == '0) begin
                        f_next     = '0;
                        state_next = ST_BD_WR;
                    end else begin
                        fail_re    = 1'b1;
                        fail_raddr = q_reg;
                        state_next = ST_BD_FT;
                    end
                end
            end
            ST_BD_FT: begin
                t_next     = fail_q;
                goto_re    = 1'b1;
                goto_raddr = {fail_q, s_reg};
                state_next = ST_BD_FN;
            end
            ST_BD_FN: begin
                if (goto_q != '0) begin
                    f_next     = goto_q;
                    state_next = ST_BD_WR;
                end else if (t_reg == '0) begin
                    f_next     = '0;
                    state_next = ST_BD_WR;
                end else begin
                    fail_re    = 1'b1;
                    fail_raddr = t_reg;
                    state_next = ST_BD_FT;
                end
            end
            ST_BD_WR: begin
                fail_we    = 1'b1;
                fail_waddr = c_reg;
                fail_wdata = f_reg;
                if (tail_reg < BW'(MAX_NODES)) begin
                    q_we      = 1'b1;
                    q_waddr   = tail_reg[NW-1:0];
                    q_wdata   = c_reg;
                    tail_next = tail_reg + BW'(1);
                end
                if (s_reg == SW'(ALPHABET - 1)) begin
                    state_next = ST_BD_POP;
                end else begin
                    s_next     = s_reg + SW'(1);
                    goto_re    = 1'b1;
                    goto_raddr = {q_reg, s_reg + SW'(1)};
                    state_next = ST_BD_EC;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_kind_next         = res_kind_reg;
                    m_out_byte_next     = res_byte_reg;
                    m_match_length_next = res_len_reg;
                    m_match_label_next  = res_label_reg;
                    m_first_time_next   = res_first_reg;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            node_count_reg   <= BW'(1);
            label_count_reg  <= '0;
            load_cursor_reg  <= '0;
            load_depth_reg   <= '0;
            load_discard_reg <= 1'b0;
            match_cursor_reg <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            node_count_reg   <= node_count_next;
            label_count_reg  <= label_count_next;
            load_cursor_reg  <= load_cursor_next;
            load_depth_reg   <= load_depth_next;
            load_discard_reg <= load_discard_next;
            match_cursor_reg <= match_cursor_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg           <= byte_next;
        last_reg           <= last_next;
        p_reg              <= p_next;
        q_reg              <= q_next;
        c_reg              <= c_next;
        t_reg              <= t_next;
        f_reg              <= f_next;
        s_reg              <= s_next;
        res_kind_reg       <= res_kind_next;
        res_byte_reg       <= res_byte_next;
        res_len_reg        <= res_len_next;
        res_label_reg      <= res_label_next;
        res_first_reg      <= res_first_next;
        m_kind_reg         <= m_kind_next;
        m_out_byte_reg     <= m_out_byte_next;
        m_match_length_reg <= m_match_length_next;
        m_match_label_reg  <= m_match_label_next;
        m_first_time_reg   <= m_first_time_next;
    end

    always_ff @(posedge aclk) begin
        if (goto_we) begin
            goto_mem[goto_waddr] <= goto_wdata;
        end
        if (goto_re) begin
            goto_q <= goto_mem[goto_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (fail_we) begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        if (fail_re) begin
            fail_q <= fail_mem[fail_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (end_we) begin
            end_mem[end_waddr] <= end_wdata;
        end
        if (nl_re) begin
            end_q <= end_mem[nl_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (lab_we) begin
            label_mem[lab_waddr] <= lab_wdata;
        end
        if (nl_re) begin
            label_q <= label_mem[nl_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_we) begin
            queue_mem[q_waddr] <= q_wdata;
        end
        if (q_re) begin
            queue_q <= queue_mem[q_raddr];
        end
    end

    `MPBM_ASSERT_IMP(a_no_accept_in_clear, aclk, aresetn,
        state_reg == ST_CLEAR, !s_ready, "word accepted during clearing pass")
    `MPBM_ASSERT_IMP(a_match_fields, aclk, aresetn,
        m_valid_reg && m_kind_reg == KIND_MATCH,
        m_match_label_reg != 11'd0 && m_match_length_reg != 8'd0, "match without label")
    `MPBM_ASSERT_NXT(a_load_one_step, aclk, aresetn,
        state_reg == ST_LD_CHK, state_reg == ST_EMIT, "load check did not finish")
    `MPBM_ASSERT_IMP(a_queue_order, aclk, aresetn,
        state_reg == ST_BD_POP || state_reg == ST_BD_EC, head_reg <= tail_reg,
        "queue head passed tail")

endmodule
